FILE: rtl/core/skm_pkg.sv
// ----------------------------------------------------------------------------
// skm_pkg
// shared types and codes for the stack machine execution unit
// ----------------------------------------------------------------------------
package skm_pkg;

  typedef enum logic [1:0] {
    TAG_EMPTY = 2'd0,
    TAG_INT   = 2'd1,
    TAG_FLOAT = 2'd2
  } tag_t;

  localparam logic [2:0] MODE_LOAD   = 3'd0;
  localparam logic [2:0] MODE_STORE  = 3'd1;
  localparam logic [2:0] MODE_CONST  = 3'd2;
  localparam logic [2:0] MODE_BINOP  = 3'd3;
  localparam logic [2:0] MODE_RETURN = 3'd4;

  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_SUB  = 4'd1;
  localparam logic [3:0] OP_MUL  = 4'd2;
  localparam logic [3:0] OP_DIV  = 4'd3;
  localparam logic [3:0] OP_AND  = 4'd4;
  localparam logic [3:0] OP_OR   = 4'd5;
  localparam logic [3:0] OP_XOR  = 4'd6;
  localparam logic [3:0] OP_SHR  = 4'd7;
  localparam logic [3:0] OP_SHL  = 4'd8;
  localparam logic [3:0] OP_REM  = 4'd9;
  localparam logic [3:0] OP_USHR = 4'd10;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_OVERFLOW  = 3'd1;
  localparam logic [2:0] ST_UNDERFLOW = 3'd2;
  localparam logic [2:0] ST_TYPE      = 3'd3;
  localparam logic [2:0] ST_BAD_INDEX = 3'd4;
  localparam logic [2:0] ST_DIV_ZERO  = 3'd5;
  localparam logic [2:0] ST_BAD_RET   = 3'd6;

  localparam logic CFG_STACK_LIMIT = 1'b0;
  localparam logic CFG_LOCALS      = 1'b1;

  localparam logic [31:0] FP_ZERO = 32'h0000_0000;
  localparam logic [31:0] FP_ONE  = 32'h3F80_0000;
  localparam logic [31:0] FP_TWO  = 32'h4000_0000;

  localparam logic [4:0] CFG_RESET_VAL = 5'd16;

endpackage

FILE: rtl/core/stack_machine_int_execute.sv
// ----------------------------------------------------------------------------
// stack_machine_int_execute
// typed operand stack machine: load, store, constant, int alu op, return
// ----------------------------------------------------------------------------
// result path: the instruction is captured, decoded in S_EXEC and its result registered onto the
//   output ports; div and rem first pass through S_DIV (the 32-step one-bit-per-cycle divider) and S_DWB
// issue: one instruction at a time; a new start is taken while the last
//   result is on the output ports
// reset: synchronous active low; clears tags, stack pointer, finished flag and
//   sets both limits to 16; value memories are not cleared
// results cannot be stalled: out_valid is a one-cycle strobe
module stack_machine_int_execute
  import skm_pkg::*;
#(
  parameter int STACK_DEPTH = 16,
  parameter int LOCAL_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // instruction transaction
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_mode,
  input  logic        in_is_float,
  input  logic [7:0]  in_local_index,
  input  logic signed [15:0] in_const_value,
  input  logic [3:0]  in_alu_op,
  // result strobe
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic signed [31:0] out_top_value,
  output logic        out_top_is_float,
  output logic [4:0]  out_stack_depth,
  output logic        out_finished,
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [4:0]  cfg_data
);

  localparam int SA = $clog2(STACK_DEPTH);
  localparam int LA = $clog2(LOCAL_COUNT);
  // limits are 5-bit registers, so the clamp never exceeds 31
  localparam int SD_CAP_I = (STACK_DEPTH > 31) ? 31 : STACK_DEPTH;
  localparam int LC_CAP_I = (LOCAL_COUNT > 31) ? 31 : LOCAL_COUNT;
  localparam logic [4:0] SD_CAP = 5'(SD_CAP_I);
  localparam logic [4:0] LC_CAP = 5'(LC_CAP_I);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_DIV  = 4'b0100,
    S_DWB  = 4'b1000
  } state_t;

  state_t state_r;

  // value memories, read into registers as the instruction is taken
  logic [31:0] stack_mem [STACK_DEPTH];
  logic [31:0] local_mem [LOCAL_COUNT];
  logic [31:0] rd_top_r, rd_sec_r, rd_loc_r;

  // tags live in flops so reset can empty them at once
  tag_t stack_tag_r [STACK_DEPTH];
  tag_t local_tag_r [LOCAL_COUNT];

  logic [4:0] sp_r;
  logic       done_r;
  logic [4:0] stack_limit_r, locals_r;

  // captured instruction
  logic [2:0]  mode_r;
  logic        flt_r;
  logic [7:0]  idx_r;
  logic [15:0] cv_r;
  logic [3:0]  op_r;

  // divider
  logic [31:0] dv_rem_r, dv_quo_r, dv_mb_r;
  logic [4:0]  dv_cnt_r;
  logic        dv_negq_r, dv_negr_r;

  logic accept;
  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // effective limits
  logic [4:0] eff_stack, eff_locals;
  assign eff_stack  = (stack_limit_r > SD_CAP) ? SD_CAP : stack_limit_r;
  assign eff_locals = (locals_r > LC_CAP) ? LC_CAP : locals_r;

  // ------------------------------------------------------------------------
  // execute: decode faults and work out the commit for the instruction
  // ------------------------------------------------------------------------
  tag_t        want, tag_top, tag_sec, tag_loc;
  logic        idx_ok, full;
  logic [31:0] a_op, b_op, alu_res, const_v, push_v;
  logic [4:0]  shamt;
  logic [2:0]  st_c;
  logic        push_c, lwr_c, go_div, is_divop, commit, done_c;
  logic [4:0]  sp_c, push_ptr;
  tag_t        push_tag;
  logic [31:0] top_c;
  logic        top_flt_c;
  logic [31:0] div_res;
  logic [32:0] dv_diff;
  logic [31:0] dv_sh;

  assign want    = flt_r ? TAG_FLOAT : TAG_INT;
  assign tag_top = stack_tag_r[SA'(sp_r - 5'd1)];
  assign tag_sec = stack_tag_r[SA'(sp_r - 5'd2)];
  assign tag_loc = local_tag_r[LA'(idx_r)];
  assign idx_ok  = (idx_r < {3'b000, eff_locals});
  assign full    = (sp_r >= eff_stack);
  assign a_op    = rd_sec_r;
  assign b_op    = rd_top_r;
  assign shamt   = b_op[4:0];
  assign is_divop = (op_r == OP_DIV) || (op_r == OP_REM);

  // divider result with sign fix; min / -1 wraps naturally
  assign div_res = (op_r == OP_DIV) ? (dv_negq_r ? (32'd0 - dv_quo_r) : dv_quo_r)
                                    : (dv_negr_r ? (32'd0 - dv_rem_r) : dv_rem_r);

  always_comb begin
    alu_res = 32'd0;
    case (op_r)
      OP_ADD:  alu_res = a_op + b_op;
      OP_SUB:  alu_res = a_op - b_op;
      OP_MUL:  alu_res = a_op * b_op;
      OP_AND:  alu_res = a_op & b_op;
      OP_OR:   alu_res = a_op | b_op;
      OP_XOR:  alu_res = a_op ^ b_op;
      OP_SHR:  alu_res = 32'($signed(a_op) >>> shamt);
      OP_SHL:  alu_res = a_op << shamt;
      OP_USHR: alu_res = a_op >> shamt;
      default: alu_res = div_res;
    endcase
  end

  always_comb begin
    const_v = {{16{cv_r[15]}}, cv_r};
    if (flt_r) begin
      case (cv_r)
        16'd0:   const_v = FP_ZERO;
        16'd1:   const_v = FP_ONE;
        default: const_v = FP_TWO;
      endcase
    end
  end

  always_comb begin
    st_c     = ST_OK;
    push_c   = 1'b0;
    lwr_c    = 1'b0;
    go_div   = 1'b0;
    sp_c     = sp_r;
    push_ptr = sp_r;
    push_v   = 32'd0;
    push_tag = want;
    done_c   = done_r;
    case (mode_r)
      MODE_LOAD: begin
        if (!idx_ok) st_c = ST_BAD_INDEX;
        else if (tag_loc != want) st_c = ST_TYPE;
        else if (full) st_c = ST_OVERFLOW;
        else begin
          push_c = 1'b1;
          push_v = rd_loc_r;
          sp_c   = sp_r + 5'd1;
        end
      end
      MODE_STORE: begin
        if (sp_r == 5'd0) st_c = ST_UNDERFLOW;
        else if (tag_top != want) st_c = ST_TYPE;
        else if (!idx_ok) st_c = ST_BAD_INDEX;
        else begin
          lwr_c = 1'b1;
          sp_c  = sp_r - 5'd1;
        end
      end
      MODE_CONST: begin
        if (flt_r && (cv_r != 16'd0) && (cv_r != 16'd1) && (cv_r != 16'd2))
          st_c = ST_BAD_INDEX;
        else if (full) st_c = ST_OVERFLOW;
        else begin
          push_c = 1'b1;
          push_v = const_v;
          sp_c   = sp_r + 5'd1;
        end
      end
      MODE_BINOP: begin
        if (sp_r < 5'd2) st_c = ST_UNDERFLOW;
        else if ((tag_top != TAG_INT) || (tag_sec != TAG_INT)) st_c = ST_TYPE;
        else if (op_r > OP_USHR) st_c = ST_BAD_INDEX;
        else if (is_divop && (b_op == 32'd0)) st_c = ST_DIV_ZERO;
        else if (is_divop && (state_r == S_EXEC)) go_div = 1'b1;
        else begin
          push_c   = 1'b1;
          push_v   = alu_res;
          push_tag = TAG_INT;
          push_ptr = sp_r - 5'd2;
          sp_c     = sp_r - 5'd1;
        end
      end
      MODE_RETURN: begin
        if (sp_r != 5'd0) st_c = ST_BAD_RET;
        else done_c = 1'b1;
      end
      default: st_c = ST_BAD_INDEX;
    endcase
  end

  assign commit = ((state_r == S_EXEC) && !go_div) || (state_r == S_DWB);

  // top of stack after the instruction
  always_comb begin
    if (sp_c == 5'd0) begin
      top_c     = 32'd0;
      top_flt_c = 1'b0;
    end else if (push_c) begin
      top_c     = push_v;
      top_flt_c = (push_tag == TAG_FLOAT);
    end else if (sp_c == sp_r) begin
      top_c     = rd_top_r;
      top_flt_c = (tag_top == TAG_FLOAT);
    end else begin
      top_c     = rd_sec_r;
      top_flt_c = (tag_sec == TAG_FLOAT);
    end
  end

  // restoring divider step
  assign dv_sh   = {dv_rem_r[30:0], dv_quo_r[31]};
  assign dv_diff = {1'b0, dv_sh} - {1'b0, dv_mb_r};

  // ------------------------------------------------------------------------
  // memories
  // ------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_top_r <= stack_mem[SA'(sp_r - 5'd1)];
      rd_sec_r <= stack_mem[SA'(sp_r - 5'd2)];
      rd_loc_r <= local_mem[LA'(in_local_index)];
    end
    if (commit && push_c) begin
      stack_mem[SA'(push_ptr)] <= push_v;
    end
    if (commit && lwr_c) begin
      local_mem[LA'(idx_r)] <= rd_top_r;
    end
  end

  // ------------------------------------------------------------------------
  // control, tags and datapath registers
  // ------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      flt_r  <= in_is_float;
      idx_r  <= in_local_index;
      cv_r   <= in_const_value;
      op_r   <= in_alu_op;
    end
    if (go_div) begin
      dv_rem_r  <= 32'd0;
      dv_quo_r  <= a_op[31] ? (32'd0 - a_op) : a_op;
      dv_mb_r   <= b_op[31] ? (32'd0 - b_op) : b_op;
      dv_negq_r <= a_op[31] ^ b_op[31];
      dv_negr_r <= a_op[31];
    end else if (state_r == S_DIV) begin
      if (!dv_diff[32]) begin
        dv_rem_r <= dv_diff[31:0];
        dv_quo_r <= {dv_quo_r[30:0], 1'b1};
      end else begin
        dv_rem_r <= dv_sh;
        dv_quo_r <= {dv_quo_r[30:0], 1'b0};
      end
    end
    if (commit) begin
      out_status       <= st_c;
      out_top_value    <= top_c;
      out_top_is_float <= top_flt_c;
      out_stack_depth  <= sp_c;
      out_finished     <= done_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      sp_r          <= 5'd0;
      done_r        <= 1'b0;
      stack_limit_r <= CFG_RESET_VAL;
      locals_r      <= CFG_RESET_VAL;
      out_valid     <= 1'b0;
      dv_cnt_r      <= 5'd0;
      for (int i = 0; i < STACK_DEPTH; i++) stack_tag_r[i] <= TAG_EMPTY;
      for (int i = 0; i < LOCAL_COUNT; i++) local_tag_r[i] <= TAG_EMPTY;
    end else begin
      out_valid <= commit;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_STACK_LIMIT) stack_limit_r <= cfg_data;
        else locals_r <= cfg_data;
      end
      if (commit) begin
        sp_r   <= sp_c;
        done_r <= done_c;
        if (push_c) stack_tag_r[SA'(push_ptr)] <= push_tag;
        if (lwr_c) local_tag_r[LA'(idx_r)] <= want;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) state_r <= S_EXEC;
        end
        S_EXEC: begin
          if (go_div) begin
            state_r  <= S_DIV;
            dv_cnt_r <= 5'd31;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_DIV: begin
          // one quotient bit per cycle
          dv_cnt_r <= dv_cnt_r - 5'd1;
          if (dv_cnt_r == 5'd0) state_r <= S_DWB;
        end
        S_DWB: begin
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the typed stack machine execution unit: directed
// instructions for every mode and op and for each fault but overflow, then random
// instruction streams under several frame limits, checked against an in-bench stack predictor
// ----------------------------------------------------------------------------
module tb_top
  import skm_pkg::*;
;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_mode = '0;
  logic        in_is_float = 1'b0;
  logic [7:0]  in_local_index = '0;
  logic signed [15:0] in_const_value = '0;
  logic [3:0]  in_alu_op = '0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic signed [31:0] out_top_value;
  logic        out_top_is_float;
  logic [4:0]  out_stack_depth;
  logic        out_finished;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [4:0]  cfg_data = '0;

  stack_machine_int_execute i_dut (.*);

  always #5 clk = ~clk;

  // expected result of one instruction
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] top_value;
    logic        top_is_float;
    logic [4:0]  stack_depth;
    logic        finished;
  } step_result_t;

  step_result_t expected_results[$];
  int errors = 0;
  int cycles = 0;
  bit idle_on = 1'b1;

  // shadow machine state
  logic [31:0] stk_val [16];
  tag_t        stk_tag [16];
  logic [31:0] loc_val [16];
  tag_t        loc_tag [16];
  int          sp;
  bit          done;
  logic [4:0]  lim_stack;
  logic [4:0]  lim_locals;

  // 32-bit int alu, a = second entry, b = top; returns status
  function automatic logic [2:0] int_alu(logic [3:0] op, logic [31:0] a, logic [31:0] b,
                                         output logic [31:0] r);
    logic [31:0] ma, mb, q, rm;
    logic [4:0]  s;
    s = b[4:0];
    r = '0;
    case (op)
      OP_ADD:  r = a + b;
      OP_SUB:  r = a - b;
      OP_MUL:  r = a * b;
      OP_DIV, OP_REM: begin
        if (b == 0) return ST_DIV_ZERO;
        // magnitudes keep MIN / -1 well defined
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q  = ma / mb;
        rm = ma % mb;
        if (op == OP_DIV) r = (a[31] != b[31]) ? -q : q;
        else r = a[31] ? -rm : rm;
      end
      OP_AND:  r = a & b;
      OP_OR:   r = a | b;
      OP_XOR:  r = a ^ b;
      OP_SHR:  r = $signed(a) >>> s;
      OP_SHL:  r = a << s;
      OP_USHR: r = a >> s;
      default: return ST_BAD_INDEX;
    endcase
    return ST_OK;
  endfunction

  function automatic logic [2:0] exec_instr(logic [2:0] mode, logic isf, logic [7:0] idx,
                                            logic [15:0] cv, logic [3:0] op);
    int          slim, llim;
    tag_t        want;
    logic [31:0] v, r;
    logic [2:0]  st;
    slim = (lim_stack > 16) ? 16 : lim_stack;
    llim = (lim_locals > 16) ? 16 : lim_locals;
    want = isf ? TAG_FLOAT : TAG_INT;
    case (mode)
      MODE_LOAD: begin
        if (idx >= llim) return ST_BAD_INDEX;
        if (loc_tag[idx[3:0]] != want) return ST_TYPE;
        if (sp >= slim) return ST_OVERFLOW;
        stk_val[sp] = loc_val[idx[3:0]];
        stk_tag[sp] = want;
        sp++;
      end
      MODE_STORE: begin
        if (sp == 0) return ST_UNDERFLOW;
        if (stk_tag[sp-1] != want) return ST_TYPE;
        if (idx >= llim) return ST_BAD_INDEX;
        sp--;
        loc_val[idx[3:0]] = stk_val[sp];
        loc_tag[idx[3:0]] = want;
      end
      MODE_CONST: begin
        v = {{16{cv[15]}}, cv};
        if (isf) begin
          if (cv == 16'd0) v = FP_ZERO;
          else if (cv == 16'd1) v = FP_ONE;
          else if (cv == 16'd2) v = FP_TWO;
          else return ST_BAD_INDEX;
        end
        if (sp >= slim) return ST_OVERFLOW;
        stk_val[sp] = v;
        stk_tag[sp] = want;
        sp++;
      end
      MODE_BINOP: begin
        if (sp < 2) return ST_UNDERFLOW;
        if (stk_tag[sp-1] != TAG_INT || stk_tag[sp-2] != TAG_INT) return ST_TYPE;
        st = int_alu(op, stk_val[sp-2], stk_val[sp-1], r);
        if (st != ST_OK) return st;
        sp -= 2;
        stk_val[sp] = r;
        stk_tag[sp] = TAG_INT;
        sp++;
      end
      MODE_RETURN: begin
        if (sp != 0) return ST_BAD_RET;
        done = 1'b1;
      end
      default: return ST_BAD_INDEX;
    endcase
    return ST_OK;
  endfunction

  task automatic predict_step(logic [2:0] mode, logic isf, logic [7:0] idx,
                              logic [15:0] cv, logic [3:0] op);
    step_result_t e;
    e.status       = exec_instr(mode, isf, idx, cv, op);
    e.top_value    = (sp > 0) ? stk_val[sp-1] : '0;
    e.top_is_float = (sp > 0) && (stk_tag[sp-1] == TAG_FLOAT);
    e.stack_depth  = sp[4:0];
    e.finished     = done;
    expected_results.push_back(e);
  endtask

  // one instruction transaction; inputs move on falling edges only
  task automatic send(logic [2:0] mode, logic isf, logic [7:0] idx,
                      logic [15:0] cv, logic [3:0] op);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    start = 1'b1;
    in_mode = mode;
    in_is_float = isf;
    in_local_index = idx;
    in_const_value = cv;
    in_alu_op = op;
    while (busy) @(negedge clk);
    @(posedge clk);
    predict_step(mode, isf, idx, cv, op);
  endtask

  // wait for every result, then let the divider run out
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [4:0] data);
    drain();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    if (idx == CFG_STACK_LIMIT) lim_stack = data;
    else lim_locals = data;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // random instruction, biased toward sequences that keep the stack useful
  task automatic rand_item();
    int          w;
    logic [2:0]  mode;
    logic        isf;
    logic [7:0]  idx;
    logic [15:0] cv;
    logic [3:0]  op;
    w = $urandom_range(0, 99);
    if (sp > 6 && w < 40) w = w + 40;   // deep stack: lean to pops
    if (w < 28) mode = MODE_CONST;
    else if (w < 42) mode = MODE_LOAD;
    else if (w < 58) mode = MODE_STORE;
    else if (w < 92) mode = MODE_BINOP;
    else if (w < 97) mode = MODE_RETURN;
    else mode = 3'($urandom_range(5, 7));
    isf = ($urandom_range(0, 4) == 0);
    idx = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 17));
    case ($urandom_range(0, 3))
      0: cv = 16'($urandom);
      1: cv = 16'($signed($urandom_range(0, 6)) - 3);
      2: cv = 16'($urandom_range(0, 2));
      default: cv = 16'($urandom_range(0, 40));
    endcase
    op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                      : 4'($urandom_range(0, 10));
    send(mode, isf, idx, cv, op);
  endtask

  // result checker: strobe is one cycle, sampled at the rising edge
  always @(posedge clk) begin
    step_result_t e;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_status);
          errors++;
        end
        if (out_top_value !== e.top_value) begin
          $error("top_value exp %h got %h", e.top_value, out_top_value);
          errors++;
        end
        if (out_top_is_float !== e.top_is_float) begin
          $error("top_is_float exp %0b got %0b", e.top_is_float, out_top_is_float);
          errors++;
        end
        if (out_stack_depth !== e.stack_depth) begin
          $error("stack_depth exp %0d got %0d", e.stack_depth, out_stack_depth);
          errors++;
        end
        if (out_finished !== e.finished) begin
          $error("finished exp %0b got %0b", e.finished, out_finished);
          errors++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > 600000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic test_directed();
    send(MODE_RETURN, 1'b0, 8'd0, 16'd0, OP_ADD);     // empty-stack return
    send(MODE_STORE, 1'b0, 8'd0, 16'd0, OP_ADD);      // underflow
    send(MODE_LOAD, 1'b0, 8'd3, 16'd0, OP_ADD);       // load of empty local
    send(MODE_CONST, 1'b0, 8'd0, 16'h8000, OP_ADD);
    send(MODE_CONST, 1'b0, 8'd0, 16'h7FFF, OP_ADD);
    send(MODE_RETURN, 1'b1, 8'd0, 16'd0, OP_ADD);     // nonempty return
    send(MODE_BINOP, 1'b0, 8'd0, 16'd0, OP_SUB);      // second minus top
    send(MODE_CONST, 1'b1, 8'd0, 16'd1, OP_ADD);
    send(MODE_CONST, 1'b1, 8'd0, 16'd3, OP_ADD);      // bad float constant
    send(MODE_BINOP, 1'b0, 8'd0, 16'd0, OP_ADD);      // float operand
    send(MODE_STORE, 1'b0, 8'd5, 16'd0, OP_ADD);      // tag mismatch on store
    send(MODE_STORE, 1'b1, 8'hFF, 16'd0, OP_ADD);     // bad index
    send(MODE_STORE, 1'b1, 8'd15, 16'd0, OP_ADD);
    send(MODE_LOAD, 1'b1, 8'd15, 16'd0, OP_ADD);
    send(MODE_LOAD, 1'b0, 8'd15, 16'd0, OP_ADD);      // wrong type load
    send(MODE_STORE, 1'b1, 8'd15, 16'd0, OP_ADD);
    send(MODE_CONST, 1'b0, 8'd0, 16'hFFFF, OP_ADD);
    send(MODE_BINOP, 1'b0, 8'd0, 16'd0, OP_DIV);      // divide by -1
    send(MODE_CONST, 1'b0, 8'd0, 16'd0, OP_ADD);
    send(MODE_BINOP, 1'b0, 8'd0, 16'd0, OP_REM);      // divide by zero
    send(MODE_BINOP, 1'b0, 8'd0, 16'd0, 4'd15);       // unused op
    send(3'd7, 1'b0, 8'd0, 16'd0, OP_ADD);            // unused mode
    for (int op = 0; op <= 10; op++) begin
      send(MODE_CONST, 1'b0, 8'd0, 16'($urandom), OP_ADD);
      send(MODE_BINOP, 1'b0, 8'd0, 16'd0, 4'(op));
    end
  endtask

  task automatic test_random(logic [4:0] slim, logic [4:0] llim, int n);
    write_cfg(CFG_STACK_LIMIT, slim);
    write_cfg(CFG_LOCALS, llim);
    repeat (n) rand_item();
  endtask

  initial begin
    sp = 0;
    done = 1'b0;
    lim_stack = CFG_RESET_VAL;
    lim_locals = CFG_RESET_VAL;
    for (int i = 0; i < 16; i++) begin
      stk_val[i] = '0;
      stk_tag[i] = TAG_EMPTY;
      loc_val[i] = '0;
      loc_tag[i] = TAG_EMPTY;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random(5'd16, 5'd16, 300);
    test_random(5'd1, 5'd4, 150);
    test_random(5'd31, 5'd31, 250);
    test_random(5'd0, 5'd0, 60);
    test_random(5'd6, 5'd2, 200);   // pops still work after lowering the limit
    test_random(5'd3, 5'd16, 150);
    idle_on = 1'b0;                 // closing stretch back to back
    test_random(5'd16, 5'd10, 200);
    drain();

    if (errors == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (expected_results.size() != 0) $error("%0d results never arrived",
                                               expected_results.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/skm_pkg.sv
rtl/core/stack_machine_int_execute.sv
dv/tb_top.sv
